// ===== rtl/core/rusm_pkg.sv =====
// rusm_pkg: types and constants shared by the rgb unsharp mask block
// no dependencies

package rusm_pkg;

   localparam int MaxWidth    = 1024;
   localparam int MaxHeight   = 4096;
   localparam int ColBits     = 10;
   localparam int RowBits     = 12;
   localparam int WidthBits   = 11;
   localparam int HeightBits  = 13;
   localparam int ChanBits    = 8;
   localparam int CsrDataBits = 13;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // floor(x / 9) == (x * DivNineMul) >> DivNineShift for x below 32768
   localparam logic [11:0] DivNineMul   = 12'd3641;
   localparam int          DivNineShift = 15;

   typedef struct packed {
      logic [ChanBits-1:0] pix_red;
      logic [ChanBits-1:0] pix_green;
      logic [ChanBits-1:0] pix_blue;
   } req_type;

   typedef struct packed {
      logic [RowBits-1:0]  out_row;
      logic [ColBits-1:0]  out_col;
      logic [ChanBits-1:0] sharp_red;
      logic [ChanBits-1:0] sharp_green;
      logic [ChanBits-1:0] sharp_blue;
      logic                run_last;
      logic                frame_end;
   } rsp_type;

endpackage

// ===== rtl/core/rgb_unsharp_mask_3x3.sv =====
// rgb_unsharp_mask_3x3: streaming 3x3 unsharp mask on rgb pixels
// depends on rusm_pkg
//
// Pixels enter in raster order on the req_ channel (valid/ready, one pixel
// per transaction). Sharpened pixels leave on the rsp_ channel with their
// row and column, one row and one column behind the input. The user must
// write frame width and height through the csr_ write port only while the
// block is idle; the block does not enforce this. A pixel passes an input
// stage (line store read), a window stage and an output register before
// the result it releases shows on rsp_valid. While the receiver does not
// stall, inputs that release at most one result are taken one per cycle;
// at row ends and in the last row one input releases up to four results,
// one per cycle from the shared sharpen unit, and the input side stalls
// until the last of them is emitted. When the receiver stalls the output
// register holds its transaction and the stall backs up through the stages
// to req_ready. Reset clears the counters and the window and sets both
// frame registers to 1024; the line stores are not cleared.

module rgb_unsharp_mask_3x3 (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rusm_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rusm_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic                              csr_addr,
   input  logic [rusm_pkg::CsrDataBits-1:0]  csr_wdata
);

   localparam int CB = rusm_pkg::ColBits;
   localparam int RB = rusm_pkg::RowBits;
   localparam int WB = rusm_pkg::WidthBits;
   localparam int HB = rusm_pkg::HeightBits;

   logic [WB-1:0] width_ff;
   logic [HB-1:0] height_ff;
   logic [CB-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;

   logic [23:0] upper_mem [rusm_pkg::MaxWidth];
   logic [23:0] middle_mem [rusm_pkg::MaxWidth];
   logic [23:0] upper_rd_ff, middle_rd_ff;

   logic          s1_vld_ff;
   logic [23:0]   s1_px_ff;
   logic [CB-1:0] s1_j_ff;
   logic [RB-1:0] s1_i_ff;
   logic          s1_rowend_ff, s1_lastrow_ff;

   logic [23:0]   win_ff [3][3];
   logic [3:0]    s2_mask_ff;
   logic [CB-1:0] s2_j_ff;
   logic [RB-1:0] s2_i_ff;

   logic              rsp_vld_ff;
   rusm_pkg::rsp_type rsp_ff;

   logic [WB-1:0] w_eff;
   logic [HB-1:0] h_eff;
   logic          rowend, lastrow, accept;
   logic          s1_fire, s2_take, emit;
   logic [3:0]    mask_left;
   logic [1:0]    pick;
   logic [1:0]    rsel [3];
   logic [1:0]    csel [3];
   logic [23:0]   sharp_px;
   logic [RB-1:0] e_row;
   logic [CB-1:0] e_col;

   function automatic logic [7:0] sharpen_chan(input logic [11:0] sum, input logic [7:0] cen);
      logic [23:0] prod;
      logic [7:0]  smooth;
      logic [8:0]  o;
      prod   = sum * rusm_pkg::DivNineMul;
      smooth = prod[rusm_pkg::DivNineShift +: 8];
      o      = (cen > smooth) ? ({1'b0, cen} + {1'b0, cen} - {1'b0, smooth}) : {1'b0, cen};
      return o[8] ? 8'hff : o[7:0];
   endfunction

   // frame registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WB'(1024);
         height_ff <= HB'(1024);
      end else if (csr_wr_en) begin
         case (csr_addr)
            rusm_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[WB-1:0];
            rusm_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) w_eff = WB'(1);
      else if (width_ff > WB'(rusm_pkg::MaxWidth)) w_eff = WB'(rusm_pkg::MaxWidth);
      h_eff = height_ff;
      if (height_ff == '0) h_eff = HB'(1);
      else if (height_ff > HB'(rusm_pkg::MaxHeight)) h_eff = HB'(rusm_pkg::MaxHeight);
      rowend  = ({1'b0, col_ff} + WB'(1)) >= w_eff;
      lastrow = ({1'b0, row_ff} + HB'(1)) >= h_eff;
      col_in  = rowend ? '0 : col_ff + CB'(1);
      row_in  = rowend ? (lastrow ? '0 : row_ff + RB'(1)) : row_ff;
   end

   assign req_ready = !s1_vld_ff || s1_fire;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line stores: write at window update, read at accept with write bypass
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         upper_mem[s1_j_ff]  <= middle_rd_ff;
         middle_mem[s1_j_ff] <= s1_px_ff;
      end
      if (accept) begin
         if (s1_fire && s1_j_ff == col_ff) begin
            upper_rd_ff  <= middle_rd_ff;
            middle_rd_ff <= s1_px_ff;
         end else begin
            upper_rd_ff  <= upper_mem[col_ff];
            middle_rd_ff <= middle_mem[col_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (req_ready) s1_vld_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff      <= req_data;
         s1_j_ff       <= col_ff;
         s1_i_ff       <= row_ff;
         s1_rowend_ff  <= rowend;
         s1_lastrow_ff <= lastrow;
      end
   end

   // emit selection
   always_comb begin
      pick = 2'd0;
      if (s2_mask_ff[0]) pick = 2'd0;
      else if (s2_mask_ff[1]) pick = 2'd1;
      else if (s2_mask_ff[2]) pick = 2'd2;
      else pick = 2'd3;
      mask_left       = s2_mask_ff;
      mask_left[pick] = 1'b0;
      emit    = (|s2_mask_ff) && (!rsp_vld_ff || rsp_ready);
      s2_take = !(|s2_mask_ff) || (emit && mask_left == '0);
      s1_fire = s1_vld_ff && s2_take;
      if (!pick[1]) begin
         rsel[0] = (s2_i_ff >= RB'(2)) ? 2'd0 : 2'd1;
         rsel[1] = 2'd1;
         e_row   = s2_i_ff - RB'(1);
      end else begin
         rsel[0] = (s2_i_ff >= RB'(1)) ? 2'd1 : 2'd2;
         rsel[1] = 2'd2;
         e_row   = s2_i_ff;
      end
      rsel[2] = 2'd2;
      if (!pick[0]) begin
         csel[0] = (s2_j_ff >= CB'(2)) ? 2'd0 : 2'd1;
         csel[1] = 2'd1;
         csel[2] = 2'd2;
         e_col   = s2_j_ff - CB'(1);
      end else begin
         csel[0] = (s2_j_ff >= CB'(1)) ? 2'd1 : 2'd2;
         csel[1] = 2'd2;
         csel[2] = 2'd2;
         e_col   = s2_j_ff;
      end
   end

   // sharpen unit
   always_comb begin
      logic [11:0] sum_r, sum_g, sum_b;
      logic [23:0] p, cen;
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            p     = win_ff[rsel[a]][csel[b]];
            sum_r = sum_r + 12'(p[23:16]);
            sum_g = sum_g + 12'(p[15:8]);
            sum_b = sum_b + 12'(p[7:0]);
         end
      end
      cen      = win_ff[rsel[1]][csel[1]];
      sharp_px = {sharpen_chan(sum_r, cen[23:16]), sharpen_chan(sum_g, cen[15:8]),
                  sharpen_chan(sum_b, cen[7:0])};
   end

   // window and emit mask
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               win_ff[r][c] <= '0;
         s2_mask_ff <= '0;
      end else if (s1_fire) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= upper_rd_ff;
         win_ff[1][2] <= middle_rd_ff;
         win_ff[2][2] <= s1_px_ff;
         s2_mask_ff <= {s1_lastrow_ff && s1_rowend_ff,
                        s1_lastrow_ff && (s1_j_ff != '0),
                        (s1_i_ff != '0) && s1_rowend_ff,
                        (s1_i_ff != '0) && (s1_j_ff != '0)};
      end else if (emit) begin
         s2_mask_ff <= mask_left;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_i_ff <= s1_i_ff;
         s2_j_ff <= s1_j_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else if (emit) rsp_vld_ff <= 1'b1;
      else if (rsp_ready) rsp_vld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff.out_row     <= e_row;
         rsp_ff.out_col     <= e_col;
         rsp_ff.sharp_red   <= sharp_px[23:16];
         rsp_ff.sharp_green <= sharp_px[15:8];
         rsp_ff.sharp_blue  <= sharp_px[7:0];
         rsp_ff.run_last    <= (mask_left == '0);
         rsp_ff.frame_end   <= (pick == 2'd3);
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for rgb_unsharp_mask_3x3
// depends on rusm_pkg and the rgb_unsharp_mask_3x3 rtl

module tb_top;

   localparam int WatchdogLimit = 20000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   rusm_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rusm_pkg::rsp_type rsp_data;
   logic              csr_wr_en;
   logic              csr_addr;
   logic [rusm_pkg::CsrDataBits-1:0] csr_wdata;

   rgb_unsharp_mask_3x3 dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // sharpening predictor state
   logic [23:0] upper_line [rusm_pkg::MaxWidth];
   logic [23:0] middle_line [rusm_pkg::MaxWidth];
   logic [23:0] win [9];
   int unsigned col_pos, row_pos;
   int unsigned width_reg, height_reg;

   rusm_pkg::rsp_type expected_pixels[$];
   int      error_count;
   int      idle_cycles;
   bit      rsp_stall_long;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report(input string what, input rusm_pkg::rsp_type got,
                         input rusm_pkg::rsp_type want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   function automatic logic [7:0] chan(input logic [23:0] px, input int c);
      return px[8*c +: 8];
   endfunction

   function automatic rusm_pkg::rsp_type sharpen_pixel(input int unsigned rs[3],
                                                       input int unsigned cs[3],
                                                       input int unsigned row,
                                                       input int unsigned col,
                                                       input bit fe);
      rusm_pkg::rsp_type r;
      logic [7:0] o [3];
      int unsigned sum, centre, smooth, detail, v;
      for (int c = 0; c < 3; c++) begin
         sum = 0;
         for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
               sum += chan(win[rs[a]*3 + cs[b]], c);
         centre = chan(win[rs[1]*3 + cs[1]], c);
         smooth = sum / 9;
         detail = centre > smooth ? centre - smooth : 0;
         v = centre + detail;
         o[c] = v > 255 ? 8'd255 : v[7:0];
      end
      r.out_row = row[rusm_pkg::RowBits-1:0];
      r.out_col = col[rusm_pkg::ColBits-1:0];
      r.sharp_red = o[2];
      r.sharp_green = o[1];
      r.sharp_blue = o[0];
      r.run_last = 1'b0;
      r.frame_end = fe;
      return r;
   endfunction

   function automatic void predict_pixel(input rusm_pkg::req_type px_in);
      int unsigned w, h, i, j, idx, n0;
      int unsigned rs[3], cs_prev[3], cs_end[3];
      logic [23:0] px;
      bit rowend, lastrow;
      w = width_reg == 0 ? 1 :
          (width_reg > rusm_pkg::MaxWidth ? rusm_pkg::MaxWidth : width_reg);
      h = height_reg == 0 ? 1 :
          (height_reg > rusm_pkg::MaxHeight ? rusm_pkg::MaxHeight : height_reg);
      i = row_pos;
      j = col_pos;
      px = {px_in.pix_red, px_in.pix_green, px_in.pix_blue};
      idx = j < rusm_pkg::MaxWidth ? j : rusm_pkg::MaxWidth - 1;
      for (int r = 0; r < 3; r++) begin
         win[r*3] = win[r*3 + 1];
         win[r*3 + 1] = win[r*3 + 2];
      end
      win[2] = upper_line[idx];
      win[5] = middle_line[idx];
      win[8] = px;
      upper_line[idx] = middle_line[idx];
      middle_line[idx] = px;
      rowend = j + 1 >= w;
      lastrow = i + 1 >= h;
      cs_prev = '{j >= 2 ? 0 : 1, 1, 2};
      cs_end = '{j >= 1 ? 1 : 2, 2, 2};
      n0 = expected_pixels.size();
      if (i >= 1) begin
         rs = '{i >= 2 ? 0 : 1, 1, 2};
         if (j >= 1) expected_pixels.push_back(sharpen_pixel(rs, cs_prev, i - 1, j - 1, 0));
         if (rowend) expected_pixels.push_back(sharpen_pixel(rs, cs_end, i - 1, j, 0));
      end
      if (lastrow) begin
         rs = '{i >= 1 ? 1 : 2, 2, 2};
         if (j >= 1) expected_pixels.push_back(sharpen_pixel(rs, cs_prev, i, j - 1, 0));
         if (rowend) expected_pixels.push_back(sharpen_pixel(rs, cs_end, i, j, 1));
      end
      if (expected_pixels.size() > n0)
         expected_pixels[expected_pixels.size() - 1].run_last = 1'b1;
      if (rowend) begin
         col_pos = 0;
         row_pos = lastrow ? 0 : i + 1;
      end else begin
         col_pos = j + 1;
      end
   endfunction

   task automatic write_csr(input logic addr, input int unsigned value);
      csr_wr_en <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value[rusm_pkg::CsrDataBits-1:0];
      if (addr == rusm_pkg::CSR_FRAME_WIDTH) width_reg = value & 32'h7ff;
      else height_reg = value & 32'h1fff;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_pixel(input rusm_pkg::req_type px);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) :
            ($urandom_range(0, 2) == 0 ? $urandom_range(1, 2) : 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pixel(px);
   endtask

   function automatic rusm_pkg::req_type rand_pixel();
      return rusm_pkg::req_type'(24'($urandom_range(0, 24'hffffff)));
   endfunction

   // frame sizes walked in turn; every frame is sent whole so no line-store
   // entry is read before it is written
   int unsigned frame_sizes [6][2] = '{
      '{1, 1}, '{4, 3}, '{2, 1}, '{1, 4}, '{5, 4}, '{3, 2}
   };

   rusm_pkg::req_type directed_pixels [9] = '{
      24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff,
      24'hffffff, 24'h000000, 24'h808080, 24'h7f7f7f
   };

   // single pixel frame: its own neighbourhood, so output equals input
   rusm_pkg::rsp_type single_frame_rsp = '{12'd0, 10'd0, 8'hff, 8'h00, 8'h80, 1'b1, 1'b1};

   initial begin
      int unsigned w, h, sent;
      rusm_pkg::rsp_type want;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_addr = rusm_pkg::CSR_FRAME_WIDTH;
      csr_wdata = '0;
      width_reg = 1024;
      height_reg = 1024;
      col_pos = 0;
      row_pos = 0;
      error_count = 0;
      for (int k = 0; k < 9; k++) win[k] = '0;
      for (int k = 0; k < rusm_pkg::MaxWidth; k++) begin
         upper_line[k] = '0;
         middle_line[k] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero width and height act as one
      write_csr(rusm_pkg::CSR_FRAME_WIDTH, 0);
      write_csr(rusm_pkg::CSR_FRAME_HEIGHT, 0);
      send_pixel(24'hff0080);
      want = expected_pixels[0];
      if (want !== single_frame_rsp) report("single pixel frame", want, single_frame_rsp);
      req_valid <= 1'b0;
      drain();

      // directed frame 3x3 with extreme channel values
      write_csr(rusm_pkg::CSR_FRAME_WIDTH, 3);
      write_csr(rusm_pkg::CSR_FRAME_HEIGHT, 3);
      for (int k = 0; k < 9; k++) send_pixel(directed_pixels[k]);
      req_valid <= 1'b0;
      drain();

      // write oversize frame registers, then set them back to one and send a one pixel frame
      write_csr(rusm_pkg::CSR_FRAME_WIDTH, 2047);
      write_csr(rusm_pkg::CSR_FRAME_HEIGHT, 8191);
      write_csr(rusm_pkg::CSR_FRAME_WIDTH, 1);
      write_csr(rusm_pkg::CSR_FRAME_HEIGHT, 1);
      send_pixel(24'h123456);
      req_valid <= 1'b0;
      drain();

      // random frames
      sent = 0;
      while (sent < 120) begin
         foreach (frame_sizes[f]) begin
            w = frame_sizes[f][0];
            h = frame_sizes[f][1];
            if ($urandom_range(0, 3) == 0) begin
               w = $urandom_range(1, 8);
               h = $urandom_range(1, 5);
            end
            write_csr(rusm_pkg::CSR_FRAME_WIDTH, w);
            write_csr(rusm_pkg::CSR_FRAME_HEIGHT, h);
            for (int k = 0; k < w * h; k++) begin
               send_pixel(rand_pixel());
               sent++;
            end
            req_valid <= 1'b0;
            drain();
         end
      end

      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // receiver with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall_long <= 1'b0;
      end else if (rsp_stall_long) begin
         rsp_ready <= 1'b0;
         rsp_stall_long <= $urandom_range(0, 7) != 0;
      end else begin
         rsp_ready <= $urandom_range(0, 3) != 0;
         rsp_stall_long <= $urandom_range(0, 40) == 0;
      end
   end

   always @(posedge clock) begin
      rusm_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report("unexpected transaction", rsp_data, '0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.out_row !== want.out_row) report("out_row", rsp_data, want);
            if (rsp_data.out_col !== want.out_col) report("out_col", rsp_data, want);
            if (rsp_data.sharp_red !== want.sharp_red) report("sharp_red", rsp_data, want);
            if (rsp_data.sharp_green !== want.sharp_green)
               report("sharp_green", rsp_data, want);
            if (rsp_data.sharp_blue !== want.sharp_blue) report("sharp_blue", rsp_data, want);
            if (rsp_data.run_last !== want.run_last) report("run_last", rsp_data, want);
            if (rsp_data.frame_end !== want.frame_end) report("frame_end", rsp_data, want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en
          || (!req_valid && expected_pixels.size() == 0))
         idle_cycles <= 0;
      else if (idle_cycles >= WatchdogLimit) begin
         $display("== FAIL ==");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

endmodule
